// File: rtl/dq_pkg.sv
// Shared types, command and status codes for the deque with search.
package dq_pkg;

   localparam int DEPTH_DEF       = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PEEK_FIRST = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PEEK_LAST  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Decoded operation: exactly one of the kind bits is set.
   typedef struct packed {
      logic push;
      logic pop;
      logic peek;
      logic search;
      logic clear;
      logic at_front;
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] value;
   } item_type;

endpackage

// File: rtl/dq_front.sv
// Request decode stage: accepts items and classifies the command.
module dq_front
   import dq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [VALUE_W-1:0] req_value,
   output logic               dec_valid,
   input  logic               dec_stall,
   output item_type           dec_item
);

   logic     dec_valid_ff, dec_valid_in;
   item_type dec_item_ff, dec_item_in;
   op_type   op;
   logic     accept;

   always_comb begin
      op = '0;
      case (req_cmd)
         CMD_PUSH_BACK: begin
            op.push = 1'b1;
         end
         CMD_PUSH_FRONT: begin
            op.push     = 1'b1;
            op.at_front = 1'b1;
         end
         CMD_POP_BACK: begin
            op.pop = 1'b1;
         end
         CMD_POP_FRONT: begin
            op.pop      = 1'b1;
            op.at_front = 1'b1;
         end
         CMD_PEEK_FIRST: begin
            op.peek     = 1'b1;
            op.at_front = 1'b1;
         end
         CMD_PEEK_LAST: begin
            op.peek = 1'b1;
         end
         CMD_CONTAINS: begin
            op.search = 1'b1;
         end
         default: begin
            op.clear = 1'b1;
         end
      endcase
   end

   assign req_stall = dec_valid_ff & dec_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      dec_item_in  = dec_item_ff;
      dec_valid_in = dec_valid_ff & dec_stall;
      if (accept) begin
         dec_valid_in      = 1'b1;
         dec_item_in.op    = op;
         dec_item_in.value = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
      end
      dec_item_ff <= dec_item_in;
   end

   assign dec_valid = dec_valid_ff;
   assign dec_item  = dec_item_ff;

endmodule

// File: rtl/dq_fifo.sv
// Two-entry queue of decoded items between the front and back parts.
module dq_fifo
   import dq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_stall,
   output item_type out_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_stall  = (fill_ff == 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];

   assign push = in_valid & ~in_stall;
   assign pop  = out_valid & ~out_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push & ~pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop & ~push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/dq_back.sv
// Execution part: circular store, head and count, search scan and result register.
module dq_back
   import dq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  item_type            in_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic                rsp_found,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int SUMW = CW + 1;
   localparam int SW   = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [SW-1:0] entry_store_ff [DEPTH];
   logic [SW-1:0] mem_rd_ff;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [SW-1:0] key_ff, key_in;

   logic [SW-1:0]       res_value_ff, res_value_in;
   logic                res_found_ff, res_found_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [AW-1:0] rd_addr, wr_addr;
   logic [SW-1:0] wr_data;
   logic          wr_en;
   logic [AW-1:0] head_p1, head_m1;
   logic          is_full, is_empty, out_free;
   logic [SW+VALUE_W-1:0] value_wide;
   logic [CW+COUNT_W-1:0] count_wide;
   logic [SW+VALUE_W-1:0] in_wide;

   // Physical slot of a logical offset from the head; offset never exceeds DEPTH.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
      logic [SUMW-1:0] sum;
      sum = SUMW'(head) + SUMW'(off);
      if (sum >= SUMW'(DEPTH)) begin
         sum = sum - SUMW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign head_p1  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign head_m1  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign in_stall = (state_ff != S_IDLE);

   assign in_wide    = {{SW{1'b0}}, in_item.value};
   assign value_wide = {{VALUE_W{1'b0}}, res_value_ff};
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      key_in        = key_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rd_addr       = head_ff;
      wr_addr       = slot_of(head_ff, count_ff);
      wr_data       = in_wide[SW-1:0];
      wr_en         = 1'b0;

      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               res_value_in  = '0;
               res_found_in  = 1'b0;
               res_status_in = ST_OK;
               state_in      = S_DONE;
               if (in_item.op.push) begin
                  if (is_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                     if (in_item.op.at_front) begin
                        wr_addr = head_m1;
                        head_in = head_m1;
                     end
                  end
               end else if (in_item.op.pop | in_item.op.peek) begin
                  if (is_empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     state_in = S_READ;
                     rd_addr  = in_item.op.at_front ? head_ff
                                                    : slot_of(head_ff, count_ff - CW'(1));
                     if (in_item.op.pop) begin
                        count_in = count_ff - CW'(1);
                        if (in_item.op.at_front) begin
                           head_in = head_p1;
                        end
                     end
                  end
               end else if (in_item.op.search) begin
                  key_in = in_wide[SW-1:0];
                  if (!is_empty) begin
                     rd_addr     = head_ff;
                     scan_idx_in = CW'(1);
                     state_in    = S_SCAN;
                  end
               end else begin
                  count_in = '0;
                  head_in  = '0;
               end
            end
         end
         S_READ: begin
            res_value_in = mem_rd_ff;
            state_in     = S_DONE;
         end
         S_SCAN: begin
            // One entry read is issued per cycle and compared the cycle after.
            rd_addr = slot_of(head_ff, scan_idx_ff);
            if (mem_rd_ff == key_ff) begin
               res_found_in = 1'b1;
               state_in     = S_DONE;
            end else if (scan_idx_ff == count_ff) begin
               state_in = S_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + CW'(1);
            end
         end
         default: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_wide[VALUE_W-1:0];
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_wide[COUNT_W-1:0];
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      mem_rd_ff <= entry_store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff   <= scan_idx_in;
      key_ff        <= key_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

// File: rtl/double_ended_queue_with_search.sv
// An accepted item passes the decode register and the two-entry queue to the execution unit.
// There push, clear and refused requests go from idle straight to done, pop and peek pass a
// read state, and contains scans one entry per cycle until a hit or the last entry. The unit
// takes no new item until its result has moved to the result register and it is idle again.
// Reset empties the queue (head and count to zero) and clears all valid flags; the entry
// store itself is not reset and needs no clearing pass.
module double_ended_queue_with_search
   import dq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic                rsp_found,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count
);

   // The front stage decodes each item into operation flags with one kind bit set, so the back
   // part never looks at raw command codes.
   logic     dec_valid, dec_stall;
   item_type dec_item;

   // The two-entry queue lets the front keep taking items while the back part
   // is busy with a long search or waits on a stalled result.
   logic     exe_valid, exe_stall;
   item_type exe_item;

   dq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .req_value (req_value),
      .dec_valid (dec_valid),
      .dec_stall (dec_stall),
      .dec_item  (dec_item)
   );

   dq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_stall  (dec_stall),
      .in_item   (dec_item),
      .out_valid (exe_valid),
      .out_stall (exe_stall),
      .out_item  (exe_item)
   );

   // The back part owns the circular store, the head pointer and the count.
   // It finishes each item into a result register and waits in its done state until the output
   // register is free, so while a result is stalled it can finish one more item but take no other.
   dq_back #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (exe_valid),
      .in_stall       (exe_stall),
      .in_item        (exe_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

endmodule

// File: test/double_ended_queue_with_search_tb.sv
// Self-checking testbench for the deque with membership search.
`timescale 1ns / 100ps

module double_ended_queue_with_search_tb;
   import dq_pkg::*;

   localparam int DEPTH          = DEPTH_DEF;
   localparam int HEAD_W         = $clog2(DEPTH);
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_ITEMS   = 1050;
   // The longest correct quiet spell is the receiver's deliberate long hold-off plus a full-depth
   // search; the watchdog allows several times that.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 500;
   localparam int HOLD_A         = 2500;
   localparam int HOLD_B         = 6000;
   // Long enough for a search over a full queue to finish, so this covers any straggler.
   localparam int TAIL_CYCLES    = DEPTH + 40;
   localparam int MAX_PRINTS     = 40;

   // One result item, laid out in the order of the result ports.
   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic                found;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } answer_type;

   // One row of the directed script. Where typed is set, want is the result read straight
   // off the behavior; otherwise the predictor supplies the expected result.
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic               typed;
      answer_type         want;
   } script_row_type;

   // Traffic shapes for the random part.
   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_SEARCH, PH_CHURN} phase_type;

   localparam logic [CMD_W-1:0] PUSHES [2] = '{CMD_PUSH_BACK, CMD_PUSH_FRONT};
   localparam logic [CMD_W-1:0] TAKES  [2] = '{CMD_POP_BACK, CMD_POP_FRONT};
   localparam logic [CMD_W-1:0] LOOKS  [3] = '{CMD_PEEK_FIRST, CMD_PEEK_LAST, CMD_CONTAINS};
   localparam logic [VALUE_W-1:0] EDGE_VALUES [4] =
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [VALUE_W-1:0]  rsp_read_value;
   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;

   // The testbench's own picture of the queue: a circular store, the index of the first
   // entry and the number of valid entries. It is advanced once per accepted item.
   logic [VALUE_W-1:0] shadow_slots [DEPTH];
   logic [HEAD_W-1:0]  shadow_head  = '0;
   logic [COUNT_W-1:0] shadow_count = '0;

   // Results owed by the block, oldest first. Exactly one per accepted item.
   answer_type answers_due [$];

   int mismatches      = 0;
   int answers_checked = 0;
   int items_sent      = 0;
   int idle_cycles     = 0;
   int refused_full    = 0;
   int refused_empty   = 0;
   int search_hits     = 0;
   int clears_sent     = 0;
   int deepest_fill    = 0;

   // Directed script: empty-queue refusals, edge handles at both ends, head wrap-around on
   // a front push, searches that hit and miss, clear, and a search for a handle that was
   // popped and so must no longer be found.
   script_row_type script [24] = '{
      '{CMD_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, ST_EMPTY, 7'd0}},
      '{CMD_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, ST_EMPTY, 7'd0}},
      '{CMD_PEEK_FIRST, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, ST_EMPTY, 7'd0}},
      '{CMD_PEEK_LAST,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, ST_EMPTY, 7'd0}},
      '{CMD_CONTAINS,   32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, ST_OK,    7'd0}},
      '{CMD_PUSH_BACK,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, ST_OK,    7'd1}},
      '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, ST_OK,    7'd2}},
      '{CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, ST_OK,    7'd3}},
      '{CMD_PUSH_FRONT, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b0, ST_OK,    7'd4}},
      '{CMD_PEEK_FIRST, 32'h0000_0000, 1'b1, '{32'h0000_0001, 1'b0, ST_OK,    7'd4}},
      '{CMD_PEEK_LAST,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, ST_OK,    7'd4}},
      '{CMD_CONTAINS,   32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, ST_OK,    7'd4}},
      '{CMD_CONTAINS,   32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, ST_OK,    7'd4}},
      '{CMD_CONTAINS,   32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, ST_OK,    7'd4}},
      '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0000_0001, 1'b0, ST_OK,    7'd3}},
      '{CMD_POP_BACK,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b0, ST_OK,    7'd2}},
      '{CMD_POP_BACK,   32'h1234_5678, 1'b0, '0},
      '{CMD_PUSH_BACK,  32'hA5A5_A5A5, 1'b0, '0},
      '{CMD_CLEAR,      32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, ST_OK,    7'd0}},
      '{CMD_PEEK_LAST,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, ST_EMPTY, 7'd0}},
      '{CMD_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, '0},
      '{CMD_POP_BACK,   32'h0000_0000, 1'b0, '0},
      '{CMD_CONTAINS,   32'h5A5A_5A5A, 1'b1, '{32'h0000_0000, 1'b0, ST_OK,    7'd0}},
      '{CMD_CLEAR,      32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, ST_OK,    7'd0}}
   };

   double_ended_queue_with_search #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_W)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   // 10 ns clock, first rising edge at 5 ns.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Position in the circular store of the entry that lies offset places behind the head.
   function automatic int slot_of(input int offset);
      return (int'(shadow_head) + offset) % DEPTH;
   endfunction

   // Applies one request to the shadow queue and returns the result the block owes for it.
   function automatic answer_type answer_for(input logic [CMD_W-1:0] cmd,
                                             input logic [VALUE_W-1:0] value);
      answer_type a;
      int         idx;
      a = '0;
      a.status = ST_OK;
      case (cmd)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               a.status = ST_FULL;
            end else if (cmd == CMD_PUSH_BACK) begin
               shadow_slots[slot_of(int'(shadow_count))] = value;
               shadow_count = shadow_count + COUNT_W'(1);
            end else begin
               // The head steps back one place, wrapping below slot zero.
               shadow_head = HEAD_W'(slot_of(DEPTH - 1));
               shadow_slots[shadow_head] = value;
               shadow_count = shadow_count + COUNT_W'(1);
            end
         end
         CMD_POP_BACK, CMD_PEEK_LAST: begin
            if (shadow_count == 0) begin
               a.status = ST_EMPTY;
            end else begin
               a.read_value = shadow_slots[slot_of(int'(shadow_count) - 1)];
               if (cmd == CMD_POP_BACK) shadow_count = shadow_count - COUNT_W'(1);
            end
         end
         CMD_POP_FRONT, CMD_PEEK_FIRST: begin
            if (shadow_count == 0) begin
               a.status = ST_EMPTY;
            end else begin
               a.read_value = shadow_slots[shadow_head];
               if (cmd == CMD_POP_FRONT) begin
                  shadow_head  = HEAD_W'(slot_of(1));
                  shadow_count = shadow_count - COUNT_W'(1);
               end
            end
         end
         CMD_CONTAINS: begin
            // Scan from the front; only valid entries are ever compared.
            for (idx = 0; idx < int'(shadow_count) && !a.found; idx++) begin
               if (shadow_slots[slot_of(idx)] == value) a.found = 1'b1;
            end
         end
         default: begin
            shadow_count = '0;
            shadow_head  = '0;
         end
      endcase
      a.count = shadow_count;
      return a;
   endfunction

   // Gap length for either side: mostly none or short, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Length of a stretch in which the receiver takes every result offered.
   function automatic int ready_run();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
   endfunction

   // Command mix per traffic shape. Fill and drain lean hard on one end of the count so the
   // full and empty refusals are hit; churn keeps pushing and popping so the head wraps.
   function automatic logic [CMD_W-1:0] pick_cmd(input phase_type phase);
      int r;
      r = $urandom_range(0, 99);
      case (phase)
         PH_FILL:   return (r < 85) ? PUSHES[$urandom_range(0, 1)] : LOOKS[$urandom_range(0, 2)];
         PH_DRAIN:  return (r < 85) ? TAKES[$urandom_range(0, 1)] : LOOKS[$urandom_range(0, 2)];
         PH_SEARCH: begin
            if (r < 60) return CMD_CONTAINS;
            if (r < 80) return PUSHES[$urandom_range(0, 1)];
            return CMD_W'($urandom_range(CMD_POP_BACK, CMD_PEEK_LAST));
         end
         PH_CHURN: begin
            if (r < 45) return PUSHES[$urandom_range(0, 1)];
            if (r < 90) return TAKES[$urandom_range(0, 1)];
            return LOOKS[$urandom_range(0, 2)];
         end
         default:   begin
            if (r < 3) return CMD_CLEAR;
            return CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_CONTAINS));
         end
      endcase
   endfunction

   // Handle for a request. Searches mostly probe a handle that is in the queue, or one that
   // differs from a stored handle by a single bit; otherwise handles come from the edge
   // values, a small pool that makes duplicates likely, or the full 32-bit range.
   function automatic logic [VALUE_W-1:0] value_for(input logic [CMD_W-1:0] cmd);
      int                 r;
      logic [VALUE_W-1:0] held;
      r = $urandom_range(0, 99);
      if (cmd == CMD_CONTAINS && shadow_count != 0 && r < 70) begin
         held = shadow_slots[slot_of($urandom_range(0, int'(shadow_count) - 1))];
         return (r < 50) ? held : held ^ (VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
      end
      if (r < 15) return EDGE_VALUES[$urandom_range(0, 3)];
      if (r < 40) return VALUE_W'($urandom_range(0, 15));
      return VALUE_W'($urandom);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("%0t ns: MISMATCH %s", $time, msg);
   endtask

   // Offers one item and returns at the clock edge where it is accepted. Valid is only
   // lowered when a gap is taken, so back-to-back items keep it high without a glitch.
   // Random junk sits on the payload while valid is low.
   task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                             input logic has_typed, input answer_type typed, input bit steady);
      int         gap;
      answer_type predicted;
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_cmd   <= CMD_W'($urandom);
         req_value <= VALUE_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      predicted = answer_for(cmd, value);
      answers_due.push_back(has_typed ? typed : predicted);
      items_sent++;
      if (predicted.status == ST_FULL) refused_full++;
      if (predicted.status == ST_EMPTY) refused_empty++;
      if (predicted.found) search_hits++;
      if (cmd == CMD_CLEAR) clears_sent++;
      if (int'(shadow_count) > deepest_fill) deepest_fill = int'(shadow_count);
   endtask

   // Sender goes quiet until every owed result has been taken. Called only in the step of
   // an acceptance, and always waits on the clock before the next offer.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   // Random traffic in phases of different shape. The first phase always fills the queue
   // until several pushes have been refused. Fill and drain phases run until a few refusals
   // have been provoked; the others run for a random number of items. Between phases there
   // is sometimes a clear and sometimes a pause until the block has answered everything.
   task automatic run_random(input int target);
      int                 sent, budget, extra, hits, k;
      phase_type          phase;
      bit                 steady, first, bounded;
      logic [CMD_W-1:0]   cmd;
      sent  = 0;
      first = 1'b1;
      while (sent < target) begin
         phase   = first ? PH_FILL : phase_type'($urandom_range(PH_FILL, PH_CHURN));
         first   = 1'b0;
         steady  = ($urandom_range(0, 3) == 0);
         budget  = $urandom_range(30, 90);
         extra   = $urandom_range(2, 6);
         hits    = 0;
         bounded = (phase == PH_FILL || phase == PH_DRAIN);
         for (k = 0; k < 400 && sent < target && (bounded ? hits < extra : k < budget);
              k++) begin
            cmd = pick_cmd(phase);
            if (phase == PH_FILL && shadow_count == DEPTH &&
                (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT)) hits++;
            if (phase == PH_DRAIN && shadow_count == 0 &&
                (cmd == CMD_POP_BACK || cmd == CMD_POP_FRONT)) hits++;
            offer_item(cmd, value_for(cmd), 1'b0, '0, steady);
            sent++;
         end
         if ($urandom_range(0, 9) == 0) begin
            offer_item(CMD_CLEAR, VALUE_W'($urandom), 1'b0, '0, 1'b0);
            sent++;
         end
         if ($urandom_range(0, 4) == 0) hold_until_drained();
      end
   endtask

   // Receiver: alternates ready stretches and stall gaps of random length. At two fixed
   // cycle counts it holds off for a long stretch while the sender keeps offering, so the
   // block backs up and must stall its input.
   initial begin : rsp_side
      int cyc, left;
      bit stall_next;
      cyc        = 0;
      left       = 0;
      stall_next = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == HOLD_A || cyc == HOLD_B) begin
            stall_next = 1'b1;
            left       = LONG_HOLD;
         end else if (left > 0) begin
            left--;
         end else if (stall_next) begin
            stall_next = 1'b0;
            left       = ready_run();
         end else begin
            left       = idle_len();
            stall_next = (left > 0);
            if (!stall_next) left = ready_run();
         end
         rsp_stall <= stall_next;
      end
   end

   // Checker: every result taken is compared field by field with the oldest owed result.
   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing owed: value %h status %0d count %0d",
                                      rsp_read_value, rsp_status, rsp_count));
         end else begin
            want = answers_due.pop_front();
            answers_checked++;
            if (rsp_read_value !== want.read_value)
               report_mismatch($sformatf("result %0d read_value %h, expected %h",
                                         answers_checked, rsp_read_value, want.read_value));
            if (rsp_found !== want.found)
               report_mismatch($sformatf("result %0d found %b, expected %b",
                                         answers_checked, rsp_found, want.found));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                         answers_checked, rsp_status, want.status));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                         answers_checked, rsp_count, want.count));
         end
      end
   end

   // Watchdog: ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles, %0d results owed",
                  idle_cycles, answers_due.size());
         $display("double_ended_queue_with_search_tb: done, errors");
         $finish;
      end
   end

   // Main sequence: reset, directed script, pause until drained, random traffic, final drain.
   initial begin : stimulus
      int i;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_cmd   <= CMD_CLEAR;
      req_value <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(script); i++)
         offer_item(script[i].cmd, script[i].value, script[i].typed, script[i].want, 1'b0);
      hold_until_drained();

      run_random(RANDOM_ITEMS);
      hold_until_drained();
      // Let any stray result show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d scripted), checked %0d results, %0d mismatches.",
               items_sent, $size(script), answers_checked, mismatches);
      $display("Refused pushes %0d, refused reads %0d, search hits %0d, clears %0d, peak %0d.",
               refused_full, refused_empty, search_hits, clears_sent, deepest_fill);
      if (mismatches == 0) begin
         $display("double_ended_queue_with_search_tb: done, clean");
      end else begin
         $display("double_ended_queue_with_search_tb: done, errors");
      end
      $finish;
   end

endmodule
